[rtl/bhse_pkg.sv]
`timescale 1ns / 1ps
// Package for the binary heap sift engine.
// Holds the transaction structs, the action and register codes and the controller states.
// Depends on nothing.
package bhse_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int ACTION_W    = 3;
  localparam int POS_W       = 10;
  localparam int SIZE_W      = 11;
  localparam int KEY_W       = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic [ACTION_W-1:0] ACT_WRITE     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_READ      = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SIFT_DOWN = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SIFT_UP   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_BUILD     = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_ORDER     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMPARE_SIGNED = 2'd1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    position;
    logic [SIZE_W-1:0]   heap_size;
    logic [KEY_W-1:0]    key_in;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_out;
    logic [POS_W-1:0] final_position;
    logic             range_error;
  } result_t;

  typedef struct packed {
    logic heap_order;
    logic compare_signed;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SD_INIT,
    S_SD_CUR,
    S_SD_LEFT,
    S_SD_RIGHT,
    S_SD_MOVE,
    S_SU_INIT,
    S_SU_CUR,
    S_SU_PAR,
    S_END
  } state_t;

endpackage

[rtl/bhse_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module bhse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/bhse_cmp.sv]
`timescale 1ns / 1ps
// Key comparator: tells whether key p may not sit above key q under the current ordering.
// Depends on bhse_pkg.
module bhse_cmp #(
  parameter int KEY_WIDTH = 32
) (
  input  bhse_pkg::cfg_t        cfg,
  input  logic [KEY_WIDTH-1:0]  p,
  input  logic [KEY_WIDTH-1:0]  q,
  output logic                  swap
);
  import bhse_pkg::*;

  logic [KEY_WIDTH-1:0] flip;
  logic [KEY_WIDTH-1:0] pa;
  logic [KEY_WIDTH-1:0] qa;

  assign flip = cfg.compare_signed ? (KEY_WIDTH'(1) << (KEY_WIDTH - 1)) : '0;
  assign pa   = p ^ flip;
  assign qa   = q ^ flip;
  assign swap = cfg.heap_order ? (pa < qa) : (pa > qa);

endmodule

[rtl/bhse_ctrl.sv]
`timescale 1ns / 1ps
// Controller for the heap engine: decodes transactions and walks sift and build operations
// over the key RAM. Depends on bhse_pkg and bhse_cmp.
module bhse_ctrl #(
  parameter int DEPTH     = bhse_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = bhse_pkg::KEY_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  bhse_pkg::cmd_t           cmd,
  input  bhse_pkg::cfg_t           cfg,
  output logic                     done,
  output bhse_pkg::result_t        result,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [KEY_WIDTH-1:0]     mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [KEY_WIDTH-1:0]     mem_rdata
);
  import bhse_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = (AW + 2 > SIZE_W + 1) ? AW + 2 : SIZE_W + 1;

  state_t               state, state_next;
  logic [AW-1:0]        at, at_next;
  logic [AW-1:0]        best, best_next;
  logic [AW-1:0]        node, node_next;
  logic [SIZE_W-1:0]    size, size_next;
  logic [KEY_WIDTH-1:0] cur, cur_next;
  logic [KEY_WIDTH-1:0] best_key, best_key_next;
  logic                 moved, moved_next;
  logic                 is_build, is_build_next;
  result_t              result_next;
  logic                 done_next;

  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                 cmp_swap;
  logic [SW-1:0]        size_w, left_at, right_at, best_left;
  logic [AW-1:0]        parent, grand;
  logic                 pos_bad, size_bad;

  bhse_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp (
    .cfg  (cfg),
    .p    (cmp_a),
    .q    (cmp_b),
    .swap (cmp_swap)
  );

  assign size_w    = SW'(size);
  assign left_at   = (SW'(at) << 1) + SW'(1);
  assign right_at  = left_at + SW'(1);
  assign best_left = (SW'(best) << 1) + SW'(1);
  assign parent    = (at - AW'(1)) >> 1;
  assign grand     = (parent - AW'(1)) >> 1;
  assign pos_bad   = SW'(cmd.position) >= SW'(DEPTH);
  assign size_bad  = SW'(cmd.heap_size) > SW'(DEPTH);
  assign busy      = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    at       <= at_next;
    best     <= best_next;
    node     <= node_next;
    size     <= size_next;
    cur      <= cur_next;
    best_key <= best_key_next;
    moved    <= moved_next;
    is_build <= is_build_next;
    result   <= result_next;
  end

  always_comb begin
    state_next    = state;
    at_next       = at;
    best_next     = best;
    node_next     = node;
    size_next     = size;
    cur_next      = cur;
    best_key_next = best_key;
    moved_next    = moved;
    is_build_next = is_build;
    result_next   = result;
    done_next     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = at;
    mem_wdata     = cur;
    mem_re        = 1'b0;
    mem_raddr     = at;
    cmp_a         = cur;
    cmp_b         = mem_rdata;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          result_next.key_out        = '0;
          result_next.final_position = cmd.position;
          result_next.range_error    = 1'b0;
          at_next                    = AW'(cmd.position);
          size_next                  = cmd.heap_size;
          moved_next                 = 1'b0;
          is_build_next              = 1'b0;
          case (cmd.action)
            ACT_WRITE: begin
              done_next = 1'b1;
              if (pos_bad) begin
                result_next.range_error = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cmd.position);
                mem_wdata = KEY_WIDTH'(cmd.key_in);
              end
            end
            ACT_READ: begin
              if (pos_bad) begin
                result_next.range_error = 1'b1;
                done_next               = 1'b1;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(cmd.position);
                state_next = S_RD_WAIT;
              end
            end
            ACT_SIFT_DOWN: begin
              if (pos_bad || size_bad) begin
                result_next.range_error = 1'b1;
                done_next               = 1'b1;
              end else begin
                state_next = S_SD_INIT;
              end
            end
            ACT_SIFT_UP: begin
              if (pos_bad) begin
                result_next.range_error = 1'b1;
                done_next               = 1'b1;
              end else begin
                state_next = S_SU_INIT;
              end
            end
            ACT_BUILD: begin
              if (size_bad) begin
                result_next.range_error = 1'b1;
                done_next               = 1'b1;
              end else begin
                at_next       = AW'(cmd.heap_size >> 1);
                node_next     = AW'(cmd.heap_size >> 1);
                is_build_next = 1'b1;
                state_next    = S_SD_INIT;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        result_next.key_out = KEY_W'(mem_rdata);
        done_next           = 1'b1;
        state_next          = S_IDLE;
      end
      S_SD_INIT: begin
        if (left_at < size_w) begin
          mem_re     = 1'b1;
          mem_raddr  = at;
          state_next = S_SD_CUR;
        end else begin
          state_next = S_END;
        end
      end
      S_SD_CUR: begin
        cur_next   = mem_rdata;
        mem_re     = 1'b1;
        mem_raddr  = AW'(left_at);
        state_next = S_SD_LEFT;
      end
      S_SD_LEFT: begin
        cmp_a = cur;
        cmp_b = mem_rdata;
        if (cmp_swap) begin
          best_next     = AW'(left_at);
          best_key_next = mem_rdata;
        end else begin
          best_next     = at;
          best_key_next = cur;
        end
        if (right_at < size_w) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(right_at);
          state_next = S_SD_RIGHT;
        end else begin
          state_next = S_SD_MOVE;
        end
      end
      S_SD_RIGHT: begin
        cmp_a = best_key;
        cmp_b = mem_rdata;
        if (cmp_swap) begin
          best_next     = AW'(right_at);
          best_key_next = mem_rdata;
        end
        state_next = S_SD_MOVE;
      end
      S_SD_MOVE: begin
        if (best == at) begin
          state_next = S_END;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = at;
          mem_wdata  = best_key;
          at_next    = best;
          moved_next = 1'b1;
          if (best_left < size_w) begin
            mem_re     = 1'b1;
            mem_raddr  = AW'(best_left);
            state_next = S_SD_LEFT;
          end else begin
            state_next = S_END;
          end
        end
      end
      S_SU_INIT: begin
        if (at == '0) begin
          state_next = S_END;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = at;
          state_next = S_SU_CUR;
        end
      end
      S_SU_CUR: begin
        cur_next   = mem_rdata;
        mem_re     = 1'b1;
        mem_raddr  = parent;
        state_next = S_SU_PAR;
      end
      S_SU_PAR: begin
        cmp_a = mem_rdata;
        cmp_b = cur;
        if (cmp_swap) begin
          mem_we     = 1'b1;
          mem_waddr  = at;
          mem_wdata  = mem_rdata;
          at_next    = parent;
          moved_next = 1'b1;
          if (parent == '0) begin
            state_next = S_END;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = grand;
          end
        end else begin
          state_next = S_END;
        end
      end
      S_END: begin
        if (moved) begin
          mem_we    = 1'b1;
          mem_waddr = at;
          mem_wdata = cur;
        end
        if (is_build && (node != '0)) begin
          node_next  = node - AW'(1);
          at_next    = node - AW'(1);
          moved_next = 1'b0;
          state_next = S_SD_INIT;
        end else begin
          if (!is_build) begin
            result_next.final_position = POS_W'(at);
          end
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/binary_heap_sift_engine.sv]
`timescale 1ns / 1ps
// Binary heap sift engine: top level with the configuration registers, key RAM and controller.
// Depends on bhse_pkg, bhse_ram, bhse_cmp and bhse_ctrl.
//
// A transaction is accepted at a rising edge with start high and busy low; cmd carries the
// action, position, heap size and key. Every transaction gives exactly one result on result,
// marked by a one-cycle done strobe; the receiver cannot stall, so results are never held.
// Write entry, refused transactions and unknown actions answer in the cycle after acceptance,
// and busy stays low so a new transaction may be accepted in the cycle the strobe shows.
// Read entry answers through the registered RAM read and then the result register.
// Sift up at the root goes from its init state straight to the end state; elsewhere it reads
// the entry and then climbs level by level, with no further read once it reaches the root,
// as each level is one RAM read of the parent overlapped with the write of the previous level.
// Sift down goes straight to its end state when the position has no child; otherwise, at each
// level at which children are compared, the single read port reads both children in turn.
// Build runs sift down on every node from heap_size/2 to the root, so its time is the sum
// of those sift downs.
// Configuration registers are written through cfg_valid/cfg_ready, always ready, and must
// only be written while the engine is idle. Reset clears both registers and the controller;
// the key store is not cleared and an entry must be written before it is read or sifted.
module binary_heap_sift_engine #(
  parameter int DEPTH     = bhse_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = bhse_pkg::KEY_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  bhse_pkg::cmd_t                   cmd,
  output logic                             done,
  output bhse_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bhse_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                             cfg_data
);
  import bhse_pkg::*;

  localparam int AW = $clog2(DEPTH);

  cfg_t                 cfg;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [KEY_WIDTH-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEAP_ORDER:     cfg.heap_order     <= cfg_data;
        CFG_COMPARE_SIGNED: cfg.compare_signed <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bhse_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bhse_ctrl #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .cfg       (cfg),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start || busy))
    else $error("Result strobe without a transaction in progress.");

  a_finish_strobes: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("Operation finished without a result strobe.");

  a_error_at_once: assert property (@(posedge clk) disable iff (rst)
    (done && result.range_error) |-> $past(start && !busy))
    else $error("Refused transaction did not answer at once.");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re && (mem_waddr == mem_raddr)))
    else $error("Read and write of the same entry in one cycle.");

endmodule
